// ===== rtl/core/sshc_pkg.sv =====
// package for the string seed hash chain
// holds action codes, register indexes, hash constants and widths; no dependencies
package sshc_pkg;

    localparam int unsigned HashW = 64;
    localparam int unsigned ByteW = 8;
    localparam int unsigned AddrW = 5;

    typedef logic [HashW-1:0] t_word;

    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_END    = 2'd1,
        ACT_START  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_USE_ROOT = 2'd0,
        REG_ROOT     = 2'd1,
        REG_OFFSET   = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    localparam t_word OFFSET_RESET = 64'd1469598103934665603;
    localparam t_word GOLDEN_CONST = 64'h9E3779B97F4A7C15;
    localparam t_word DEFAULT_SEED = 64'h6D6574616C736565;

    // prime 0x100000001b3 as shifts: 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0
    function automatic t_word mul_fnv_prime(input t_word x);
        mul_fnv_prime = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                      + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== rtl/core/sshc_fnv_step.sv =====
// one fnv-1a byte step: xor the byte, multiply by the 64-bit prime
// depends on sshc_pkg
module sshc_fnv_step
    import sshc_pkg::*;
(
    input  t_word            i_hash,
    input  logic [ByteW-1:0] i_byte,
    output t_word            o_hash
);

    t_word mixed;

    assign mixed  = i_hash ^ {{(HashW-ByteW){1'b0}}, i_byte};
    assign o_hash = mul_fnv_prime(mixed);

endmodule

// ===== rtl/core/sshc_seed_fold.sv =====
// folds a string digest into the running seed
// depends on sshc_pkg
module sshc_seed_fold
    import sshc_pkg::*;
(
    input  t_word i_seed,
    input  t_word i_digest,
    output t_word o_seed
);

    t_word sum;

    assign sum    = i_digest + GOLDEN_CONST + (i_seed << 6) + (i_seed >> 2);
    assign o_seed = i_seed ^ sum;

endmodule

// ===== rtl/core/string_seed_hash_chain_unit.sv =====
// top level of the string seed hash chain: input register, hash and seed state,
// result register and the register port; depends on sshc_pkg, sshc_fnv_step, sshc_seed_fold
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_action, i_data_byte
// result    out        o_out_valid / i_out_stall o_seed_value, o_string_digest
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one item per cycle unless the input stalls; a taken transfer is held in the input
// register and updates the state from there; an end item loads the result register
// at the same edge at which it updates the state
// only an end item held behind a stalled full result register stalls the input
// synchronous active-low reset; no clearing pass
module string_seed_hash_chain_unit
    import sshc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_action,
    input  logic [ByteW-1:0] i_data_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [HashW-1:0] o_seed_value,
    output logic [HashW-1:0] o_string_digest,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [HashW-1:0] pwdata,
    output logic [HashW-1:0] prdata,
    output logic             pready
);

    logic             r_use_root;
    t_word            r_root_seed;
    t_word            r_hash_offset;
    logic             r_in_vld;
    t_action          r_in_action;
    logic [ByteW-1:0] r_in_byte;
    t_word            r_string_hash;
    t_word            r_seed;
    logic             r_fresh;
    logic             r_out_vld;
    t_word            r_out_seed;
    t_word            r_out_digest;

    t_reg_idx cfg_idx;
    logic     cfg_wr;
    logic     advance;
    t_word    cur_hash;
    t_word    n_byte_hash;
    t_word    n_fold_seed;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[AddrW-1:3]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            REG_USE_ROOT: prdata = {{(HashW-1){1'b0}}, r_use_root};
            REG_ROOT:     prdata = r_root_seed;
            REG_OFFSET:   prdata = r_hash_offset;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_root    <= 1'b0;
            r_root_seed   <= '0;
            r_hash_offset <= OFFSET_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_USE_ROOT: r_use_root    <= pwdata[0];
                REG_ROOT:     r_root_seed   <= pwdata;
                REG_OFFSET:   r_hash_offset <= pwdata;
                default:      ;
            endcase
        end
    end

    assign o_in_stall = r_in_vld && (r_in_action == ACT_END) && r_out_vld && i_out_stall;
    assign advance    = r_in_vld && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_action <= t_action'(i_action);
            r_in_byte   <= i_data_byte;
        end
    end

    assign cur_hash = r_fresh ? r_hash_offset : r_string_hash;

    sshc_fnv_step u_fnv_step (
        .i_hash (cur_hash),
        .i_byte (r_in_byte),
        .o_hash (n_byte_hash)
    );

    sshc_seed_fold u_seed_fold (
        .i_seed   (r_seed),
        .i_digest (cur_hash),
        .o_seed   (n_fold_seed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_hash <= OFFSET_RESET;
            r_seed        <= DEFAULT_SEED;
            r_fresh       <= 1'b1;
        end else if (advance) begin
            case (r_in_action)
                ACT_BYTE: begin
                    r_string_hash <= n_byte_hash;
                    r_fresh       <= 1'b0;
                end
                ACT_END: begin
                    r_seed  <= n_fold_seed;
                    r_fresh <= 1'b1;
                end
                ACT_START: begin
                    r_seed  <= r_use_root ? r_root_seed : DEFAULT_SEED;
                    r_fresh <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && r_in_action == ACT_END) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_action == ACT_END) begin
            r_out_seed   <= n_fold_seed;
            r_out_digest <= cur_hash;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_seed_value    = r_out_seed;
    assign o_string_digest = r_out_digest;

endmodule

// ===== rtl/core/sshc_checker.sv =====
// port-level checks for the string seed hash chain, bound to the top level
// depends on sshc_pkg and string_seed_hash_chain_unit
module sshc_checker
    import sshc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [HashW-1:0] o_seed_value,
    input logic [HashW-1:0] o_string_digest,
    input logic             psel,
    input logic             penable,
    input logic             pwrite,
    input logic [AddrW-1:0] paddr,
    input logic [HashW-1:0] pwdata,
    input logic [HashW-1:0] prdata,
    input logic             pready
);

    // input only backs up behind a full, stalled result
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without a blocked result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_seed_value) && $stable(o_string_digest)))
        else $error("stalled result changed");

    // root seed readback right after a write
    a_root_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[AddrW-1:3] == REG_ROOT) ##1
        (psel && !pwrite && paddr[AddrW-1:3] == REG_ROOT) |-> prdata == $past(pwdata))
        else $error("root seed readback mismatch");

endmodule

bind string_seed_hash_chain_unit sshc_checker u_sshc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_seed_value    (o_seed_value),
    .o_string_digest (o_string_digest),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
);

// ===== verif/string_seed_hash_chain_unit_tb.sv =====
// testbench for string_seed_hash_chain_unit: directed and random byte/end/start streams
// checked against an in-bench fold predictor; depends on sshc_pkg and the unit rtl
module string_seed_hash_chain_unit_tb;
    import sshc_pkg::*;

    localparam t_word k_fnv_prime   = 64'd1099511628211;
    localparam t_word k_golden      = 64'h9E3779B97F4A7C15;
    localparam t_word k_base_seed   = 64'h6D6574616C736565;
    localparam t_word k_offset_init = 64'd1469598103934665603;

    typedef struct {
        t_word seed;
        t_word digest;
    } t_seed_result;

    class seed_chain_tracker;
        bit           use_root;
        t_word        root_val;
        t_word        offset_val;
        t_word        str_hash;
        t_word        seed;
        bit           fresh;
        t_seed_result awaited[$];
        int unsigned  errors;

        function new();
            use_root   = 1'b0;
            root_val   = '0;
            offset_val = k_offset_init;
            str_hash   = k_offset_init;
            seed       = k_base_seed;
            fresh      = 1'b1;
            errors     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, t_word v);
            case (idx)
                REG_USE_ROOT: use_root = v[0];
                REG_ROOT:     root_val = v;
                REG_OFFSET:   offset_val = v;
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        task flag_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void take_item(t_action act, logic [ByteW-1:0] b);
            t_word        h;
            t_seed_result r;
            h = fresh ? offset_val : str_hash;
            case (act)
                ACT_BYTE: begin
                    str_hash = (h ^ {56'd0, b}) * k_fnv_prime;
                    fresh    = 1'b0;
                end
                ACT_END: begin
                    seed     = seed ^ (h + k_golden + (seed << 6) + (seed >> 2));
                    str_hash = offset_val;
                    fresh    = 1'b1;
                    r.seed   = seed;
                    r.digest = h;
                    awaited.insert(awaited.size(), r);
                end
                ACT_START: begin
                    seed     = use_root ? root_val : k_base_seed;
                    str_hash = offset_val;
                    fresh    = 1'b1;
                end
                default: ;
            endcase
        endfunction

        task check_seed(t_word got_seed, t_word got_digest);
            t_seed_result e;
            if (awaited.size() == 0) begin
                flag_mismatch($sformatf("result %h/%h with no transfer pending",
                                        got_seed, got_digest));
            end else begin
                e = awaited.pop_front();
                if (got_seed !== e.seed)
                    flag_mismatch($sformatf("seed_value got %h exp %h", got_seed, e.seed));
                if (got_digest !== e.digest)
                    flag_mismatch($sformatf("string_digest got %h exp %h",
                                            got_digest, e.digest));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_action = ACT_BYTE;
    logic [ByteW-1:0] i_data_byte = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [HashW-1:0] o_seed_value;
    logic [HashW-1:0] o_string_digest;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [HashW-1:0] pwdata = '0;
    logic [HashW-1:0] prdata;
    logic             pready;

    seed_chain_tracker sb = new();

    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    logic [3:0]  run_cnt    = '0;

    string_seed_hash_chain_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_seed_value    (o_seed_value),
        .o_string_digest (o_string_digest),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("** string_seed_hash_chain_unit: FAILED **");
        $finish;
    end

    // result side: check accepted transfers, stall on a changing pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_seed(o_seed_value, o_string_digest);
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(30, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            run_cnt <= run_cnt + 4'd1;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= run_cnt[3];
            endcase
        end
    end

    task idle_gap(int unsigned n);
        i_in_valid  <= 1'b0;
        i_action    <= 2'($urandom_range(0, 3));
        i_data_byte <= 8'($urandom_range(0, 255));
        repeat (n) @(posedge i_clk);
    endtask

    task push_item(t_action act, logic [ByteW-1:0] b);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_item(act, b);
        if (act != ACT_UNUSED)
            items_sent++;
        if (burst_left == 0) begin
            idle_gap($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    task drain_results();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task apb_access(bit wr, t_reg_idx idx, t_word v);
        t_word exp_rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            sb.set_reg(idx, v);
        end else if (idx != REG_NONE) begin
            case (idx)
                REG_USE_ROOT: exp_rd = {63'd0, sb.use_root};
                REG_ROOT:     exp_rd = sb.root_val;
                default:      exp_rd = sb.offset_val;
            endcase
            if (prdata !== exp_rd)
                sb.flag_mismatch($sformatf("read reg %0d got %h exp %h",
                                           idx, prdata, exp_rd));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task set_register(t_reg_idx idx, t_word v);
        apb_access(1'b1, idx, v);
        apb_access(1'b0, idx, '0);
    endtask

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [ByteW-1:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task configure_phase(int unsigned p);
        case (p)
            0: begin
                set_register(REG_USE_ROOT, 64'd1);
                set_register(REG_ROOT, '1);
                set_register(REG_OFFSET, '0);
            end
            1: begin
                set_register(REG_USE_ROOT, 64'd0);
                set_register(REG_ROOT, '0);
                set_register(REG_OFFSET, '1);
            end
            2: begin
                set_register(REG_USE_ROOT, '1);
                set_register(REG_OFFSET, k_offset_init);
            end
            3: begin
                set_register(REG_USE_ROOT, {rand_word() | 64'd1});
                set_register(REG_ROOT, rand_word());
                set_register(REG_OFFSET, rand_word());
            end
            4: begin
                apb_access(1'b1, REG_NONE, rand_word());
                set_register(REG_USE_ROOT, {rand_word() & ~64'd1});
                set_register(REG_OFFSET, rand_word());
            end
            default: begin
                set_register(REG_USE_ROOT, rand_word());
                set_register(REG_ROOT, rand_word());
                set_register(REG_OFFSET, rand_word());
            end
        endcase
    endtask

    task random_strings(int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                push_item(ACT_START, rand_byte());
            end else if (pick < 14) begin
                push_item(ACT_UNUSED, rand_byte());
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(0, 6);
                repeat (len) push_item(ACT_BYTE, rand_byte());
                // broken string: restart the seed mid-string
                if ($urandom_range(0, 19) == 0)
                    push_item(ACT_START, rand_byte());
                else
                    push_item(ACT_END, rand_byte());
            end
        end
    endtask

    initial begin
        int unsigned p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 6);

        // defaults after reset: end without start, empty strings, byte extremes
        push_item(ACT_END, 8'h00);
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_END, 8'hFF);
        push_item(ACT_START, 8'h00);
        push_item(ACT_END, 8'h00);
        push_item(ACT_BYTE, 8'h5A);
        push_item(ACT_START, 8'hFF);
        push_item(ACT_END, 8'h00);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_UNUSED, 8'hFF);
        push_item(ACT_BYTE, 8'h80);
        push_item(ACT_END, 8'h00);
        push_item(ACT_UNUSED, 8'h00);
        push_item(ACT_END, 8'hFF);
        push_item(ACT_BYTE, 8'hAA);
        push_item(ACT_BYTE, 8'h55);
        push_item(ACT_BYTE, 8'h0F);
        push_item(ACT_BYTE, 8'hF0);
        push_item(ACT_END, 8'h00);
        push_item(ACT_START, 8'h00);
        push_item(ACT_BYTE, 8'h7F);
        push_item(ACT_END, 8'h00);
        // partial string left open across the register writes
        push_item(ACT_BYTE, 8'h33);
        drain_results();

        for (p = 0; p < 8; p++) begin
            configure_phase(p);
            // first end uses the open string if one was left, the second an empty one
            push_item(ACT_END, rand_byte());
            push_item(ACT_END, rand_byte());
            push_item(ACT_START, rand_byte());
            push_item(ACT_END, rand_byte());
            random_strings(210);
            if ($urandom_range(0, 1) == 0)
                push_item(ACT_BYTE, rand_byte());
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
        if (sb.errors == 0) begin
            $display("** string_seed_hash_chain_unit: PASSED **");
        end else begin
            $display("** string_seed_hash_chain_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sshc_pkg.sv
rtl/core/sshc_fnv_step.sv
rtl/core/sshc_seed_fold.sv
rtl/core/string_seed_hash_chain_unit.sv
rtl/core/sshc_checker.sv
verif/string_seed_hash_chain_unit_tb.sv
